[rtl/lsi_pkg.sv]
package lsi_pkg;

  localparam int ACT_W  = 3;
  localparam int OFF_W  = 14;
  localparam int LINE_W = 9;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 10;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_QUERY  = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_TEXT_FULL  = 2'd1,
    ST_LINES_FULL = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  // Edit applied by every cell in the same cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INC,
    CELL_DEC,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     find;
    logic     query;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_REDUCE,
    S_OUT
  } fsm_state_t;

endpackage

[rtl/lsi_if.sv]
interface lsi_in_if import lsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [OFF_W-1:0]  offset;
  logic              is_newline;
  logic [LINE_W-1:0] line_number;

  modport source (output valid, action, offset, is_newline, line_number, input ready);
  modport sink   (input valid, action, offset, is_newline, line_number, output ready);
endinterface

interface lsi_out_if import lsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [LINE_W-1:0] line_index;
  logic [OFF_W-1:0]  line_start;
  logic [OFF_W-1:0]  line_end;
  logic [CNT_W-1:0]  line_count;
  logic [OFF_W-1:0]  text_length;

  modport source (output valid, status, line_index, line_start, line_end, line_count,
                  text_length, input ready);
  modport sink   (input valid, status, line_index, line_start, line_end, line_count,
                  text_length, output ready);
endinterface

[rtl/line_start_index_table_top.sv]
// Line-start index table for a text buffer.
// in_chan carries one request (action, offset, is_newline, line_number) with a
// valid/ready handshake; out_chan returns exactly one result per request.
// Each line start lives in its own cell of a row of MAX_LINES cells; an edit
// updates all cells together, each looking only at its two neighbors.
// Lookups mark the matching cell and pull its line through a registered
// 8-way OR tree of NSTG = ceil(log2(MAX_LINES)/3) levels (3 at 512 lines).
// The result register loads in S_OUT, after S_EXEC edits the cells and S_FIND
// and any S_REDUCE states fill the tree registers. One request is worked on at
// a time; in_chan.ready is high only in S_IDLE, reached when S_OUT is left.
// The result register decouples the sides: a new request is accepted while an
// earlier result waits; if out_chan.ready stays low, the next result holds in
// the tree until the result register frees up.
// Reset (rst_n low, synchronous) leaves one empty line and zero text length,
// drops any pending result and needs no clearing pass; cells beyond the line
// count are never read.
module line_start_index_table_top import lsi_pkg::*; #(
  parameter int MAX_LINES  = 512,
  parameter int TEXT_BYTES = 8192
) (
  input logic      clk,
  input logic      rst_n,
  lsi_in_if.sink   in_chan,
  lsi_out_if.source out_chan
);

  localparam int SW   = $clog2(TEXT_BYTES + 1);
  localparam int LW   = $clog2(MAX_LINES);
  localparam int CW   = $clog2(MAX_LINES + 1);
  localparam int AW   = (SW > OFF_W) ? SW : OFF_W;
  localparam int QW   = (CW > LINE_W) ? CW : LINE_W;
  localparam int PW   = LW + 2 * SW;
  localparam int NSTG = (LW + 2) / 3;
  localparam int NPAD = 1 << (3 * NSTG);
  localparam int RW   = $clog2(NSTG + 1);

  fsm_state_t state_r, state_nxt;

  logic [ACT_W-1:0]  req_action_r;
  logic [OFF_W-1:0]  req_offset_r;
  logic              req_nl_r;
  logic [LINE_W-1:0] req_line_r;

  logic [CW-1:0]     lt_r, lt_nxt;
  logic [SW-1:0]     bt_r, bt_nxt;
  status_t           status_r, status_nxt;
  logic [RW-1:0]     red_cnt_r, red_cnt_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [LINE_W-1:0] out_line_index_r;
  logic [OFF_W-1:0]  out_line_start_r;
  logic [OFF_W-1:0]  out_line_end_r;
  logic [CNT_W-1:0]  out_line_count_r;
  logic [OFF_W-1:0]  out_text_length_r;

  logic              accept;
  logic              out_load;
  cell_op_t          edit_op;
  cell_ctl_t         ctl;
  logic [AW-1:0]     off_aw;
  logic [AW-1:0]     bt_aw;
  logic [SW-1:0]     probe;
  logic [SW-1:0]     key;
  logic [QW-1:0]     q_ext;
  logic [QW-1:0]     lt_ext;
  logic [QW-1:0]     q_clamp;
  logic [LW-1:0]     line_sel;
  logic              any_gt;
  logic [PW-1:0]     res;

  wire [MAX_LINES-1:0][SW-1:0] cell_start;
  wire [MAX_LINES-1:0]         cell_valid;
  wire [MAX_LINES-1:0]         cell_le;
  wire [MAX_LINES-1:0]         cell_gt;
  wire [NSTG:0][NPAD*PW-1:0]   lvl;

  assign accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action_r <= in_chan.action;
      req_offset_r <= in_chan.offset;
      req_nl_r     <= in_chan.is_newline;
      req_line_r   <= in_chan.line_number;
    end
  end

  assign off_aw = AW'(req_offset_r);
  assign bt_aw  = AW'(bt_r);
  assign probe  = (off_aw > bt_aw) ? bt_r : off_aw[SW-1:0];
  // edits compare against the raw offset, lookups against the clamped one
  assign key    = (state_r == S_EXEC) ? off_aw[SW-1:0] : probe;

  assign q_ext    = QW'(req_line_r);
  assign lt_ext   = QW'(lt_r);
  assign q_clamp  = (q_ext >= lt_ext) ? (lt_ext - QW'(1)) : q_ext;
  assign line_sel = q_clamp[LW-1:0];

  assign any_gt = |cell_gt;

  // edit decode: status, new totals and the cell operation
  always_comb begin
    status_nxt = ST_OK;
    lt_nxt     = lt_r;
    bt_nxt     = bt_r;
    edit_op    = CELL_HOLD;
    case (action_t'(req_action_r))
      ACT_CLEAR: begin
        lt_nxt = CW'(1);
        bt_nxt = '0;
      end
      ACT_INSERT: begin
        if (bt_r == SW'(TEXT_BYTES)) begin
          status_nxt = ST_TEXT_FULL;
        end else if (req_nl_r && (lt_r == CW'(MAX_LINES))) begin
          status_nxt = ST_LINES_FULL;
        end else if (off_aw > bt_aw) begin
          status_nxt = ST_RANGE;
        end else begin
          bt_nxt  = bt_r + SW'(1);
          lt_nxt  = req_nl_r ? lt_r + CW'(1) : lt_r;
          edit_op = req_nl_r ? CELL_INS : CELL_INC;
        end
      end
      ACT_DELETE: begin
        if (off_aw >= bt_aw) begin
          status_nxt = ST_RANGE;
        end else begin
          bt_nxt  = bt_r - SW'(1);
          // a newline on the last line removes no start
          lt_nxt  = (req_nl_r && any_gt) ? lt_r - CW'(1) : lt_r;
          edit_op = req_nl_r ? CELL_DEL : CELL_DEC;
        end
      end
      ACT_QUERY: begin
        status_nxt = ST_OK;
      end
      default: begin
        if (off_aw > bt_aw) status_nxt = ST_RANGE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = S_FIND;
      S_FIND:   state_nxt = (NSTG == 1) ? S_OUT : S_REDUCE;
      S_REDUCE: if (red_cnt_r == RW'(NSTG - 1)) state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || out_chan.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_chan.ready = 1'b0;
    ctl.op        = CELL_HOLD;
    ctl.find      = 1'b0;
    ctl.query     = (action_t'(req_action_r) == ACT_QUERY);
    out_load      = 1'b0;
    red_cnt_nxt   = red_cnt_r;
    case (state_r)
      S_IDLE: in_chan.ready = 1'b1;
      S_EXEC: ctl.op = edit_op;
      S_FIND: begin
        ctl.find    = 1'b1;
        red_cnt_nxt = RW'(1);
      end
      S_REDUCE: begin
        ctl.find    = 1'b1;
        red_cnt_nxt = red_cnt_r + RW'(1);
      end
      S_OUT: begin
        // hold the lookup so the tree output stays put while stalled
        ctl.find = 1'b1;
        out_load = !out_valid_r || out_chan.ready;
      end
      default: in_chan.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lt_r      <= CW'(1);
      bt_r      <= '0;
      red_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      red_cnt_r <= red_cnt_nxt;
      if (state_r == S_EXEC) begin
        lt_r <= lt_nxt;
        bt_r <= bt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) status_r <= status_nxt;
  end

  genvar i;
  generate
    for (i = 0; i < MAX_LINES; i++) begin : g_cell
      wire [SW-1:0] p_start;
      wire          p_le;
      wire          p_gt;
      wire [SW-1:0] n_start;
      wire          n_valid;
      wire          n_le;

      if (i == 0) begin : g_head
        assign p_start = '0;
        assign p_le    = 1'b0;
        assign p_gt    = 1'b0;
      end else begin : g_mid
        assign p_start = cell_start[i-1];
        assign p_le    = cell_le[i-1];
        assign p_gt    = cell_gt[i-1];
      end

      if (i == MAX_LINES - 1) begin : g_tail
        assign n_start = '0;
        assign n_valid = 1'b0;
        assign n_le    = 1'b0;
      end else begin : g_body
        assign n_start = cell_start[i+1];
        assign n_valid = cell_valid[i+1];
        assign n_le    = cell_le[i+1];
      end

      lsi_cell #(
        .IDX (i),
        .SW  (SW),
        .LW  (LW),
        .CW  (CW)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .key        (key),
        .line_total (lt_r),
        .byte_total (bt_r),
        .line_sel   (line_sel),
        .prev_start (p_start),
        .prev_le    (p_le),
        .prev_gt    (p_gt),
        .next_start (n_start),
        .next_valid (n_valid),
        .next_le    (n_le),
        .start      (cell_start[i]),
        .valid      (cell_valid[i]),
        .le         (cell_le[i]),
        .gt         (cell_gt[i]),
        .hit_data   (lvl[0][i*PW +: PW])
      );
    end

    if (NPAD > MAX_LINES) begin : g_pad
      assign lvl[0][NPAD*PW-1:MAX_LINES*PW] = '0;
    end

    for (i = 1; i <= NSTG; i++) begin : g_tree
      localparam int NO = NPAD >> (3 * i);

      lsi_or_stage #(
        .W     (PW),
        .N_OUT (NO)
      ) u_stage (
        .clk    (clk),
        .din    (lvl[i-1][NO*8*PW-1:0]),
        .dout_r (lvl[i][NO*PW-1:0])
      );

      if (NO < NPAD) begin : g_fill
        assign lvl[i][NPAD*PW-1:NO*PW] = '0;
      end
    end
  endgenerate

  assign res = lvl[NSTG][PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r      <= status_r;
      out_line_index_r  <= LINE_W'(res[PW-1 -: LW]);
      out_line_start_r  <= OFF_W'(res[2*SW-1:SW]);
      out_line_end_r    <= OFF_W'(res[SW-1:0]);
      out_line_count_r  <= CNT_W'(lt_r);
      out_text_length_r <= OFF_W'(bt_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.line_index  = out_line_index_r;
  assign out_chan.line_start  = out_line_start_r;
  assign out_chan.line_end    = out_line_end_r;
  assign out_chan.line_count  = out_line_count_r;
  assign out_chan.text_length = out_text_length_r;

endmodule

[rtl/lsi_cell.sv]
module lsi_cell import lsi_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW  = 14,
  parameter int LW  = 9,
  parameter int CW  = 10
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [SW-1:0]      key,
  input  logic [CW-1:0]      line_total,
  input  logic [SW-1:0]      byte_total,
  input  logic [LW-1:0]      line_sel,
  input  logic [SW-1:0]      prev_start,
  input  logic               prev_le,
  input  logic               prev_gt,
  input  logic [SW-1:0]      next_start,
  input  logic               next_valid,
  input  logic               next_le,
  output logic [SW-1:0]      start,
  output logic               valid,
  output logic               le,
  output logic               gt,
  output logic [LW+2*SW-1:0] hit_data
);

  logic [SW-1:0] start_r;
  logic [SW-1:0] start_nxt;
  logic [SW-1:0] own_dec;
  logic [SW-1:0] next_dec;
  logic [SW-1:0] line_end;
  logic          hit;

  // Line zero always begins at offset zero
  assign start = (IDX == 0) ? '0 : start_r;

  assign valid    = (CW'(IDX) < line_total);
  assign le       = valid && (start <= key);
  assign gt       = valid && !le;
  assign own_dec  = (start == '0) ? '0 : start - SW'(1);
  assign next_dec = (next_start == '0) ? '0 : next_start - SW'(1);
  assign line_end = next_valid ? next_dec : byte_total;

  always_comb begin
    start_nxt = start;
    case (ctl.op)
      CELL_INC: begin
        if (gt) start_nxt = start + SW'(1);
      end
      CELL_DEC: begin
        if (gt) start_nxt = own_dec;
      end
      CELL_INS: begin
        // shift right past the edit point, first cell beyond it takes the new start
        if (prev_gt) begin
          start_nxt = prev_start + SW'(1);
        end else if (prev_le && !le) begin
          start_nxt = key + SW'(1);
        end
      end
      CELL_DEL: begin
        if (gt && next_valid) start_nxt = next_dec;
      end
      default: start_nxt = start;
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

  assign hit = ctl.find && (ctl.query ? (line_sel == LW'(IDX)) : (le && !next_le));
  assign hit_data = {LW'(IDX), start, line_end} & {(LW+2*SW){hit}};

endmodule

[rtl/lsi_or_stage.sv]
module lsi_or_stage #(
  parameter int W     = 37,
  parameter int N_OUT = 64
) (
  input  logic                 clk,
  input  logic [N_OUT*8*W-1:0] din,
  output logic [N_OUT*W-1:0]   dout_r
);

  logic [N_OUT*W-1:0] dout_nxt;

  // Hits are one-hot, so an OR picks the single live entry
  always_comb begin
    dout_nxt = '0;
    for (int o = 0; o < N_OUT; o++) begin
      for (int j = 0; j < 8; j++) begin
        dout_nxt[o*W +: W] = dout_nxt[o*W +: W] | din[(o*8+j)*W +: W];
      end
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

endmodule
